>>> rtl/otp_pkg.sv
`default_nettype none

package otp_pkg;

    // default accumulator width
    localparam int OCC_BITS_DEF = 20;

    // fixed field widths
    localparam int IDX_W      = 20;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // characters of the occurrence text
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_COMMA = 8'h2c;  // ','

    // highest dimension slot
    localparam logic [1:0] LAST_DIM = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECORD_LIMIT    = 2'd0,
        CFG_ITEM_LIMIT      = 2'd1,
        CFG_IS_SUBITEM      = 2'd2,
        CFG_MULTIPLE_OCCURS = 2'd3
    } t_cfg_reg;

    // configuration register file
    typedef struct packed {
        logic [LIMIT_W-1:0] record_limit;
        logic [LIMIT_W-1:0] item_limit;
        logic               is_subitem;
        logic               multiple_occurs;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        record_limit:    16'd1,
        item_limit:      16'd1,
        is_subitem:      1'b0,
        multiple_occurs: 1'b0
    };

    // parser control state
    typedef struct packed {
        logic [1:0] ptr;
        logic       paren_allowed;
        logic       paren_seen;
        logic       close_seen;
        logic       error;
    } t_parse_flags;

    localparam t_parse_flags FLAGS_RESET = '{
        ptr:           2'd0,
        paren_allowed: 1'b1,
        paren_seen:    1'b0,
        close_seen:    1'b0,
        error:         1'b0
    };

    // input item
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]       parse_result;
        logic [IDX_W-1:0] record_index;
        logic [IDX_W-1:0] itm_index;
        logic [IDX_W-1:0] subitem_index;
        logic             accepted;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/otp_stream_if.sv
`default_nettype none

interface otp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/otp_eval.sv
`default_nettype none

module otp_eval
    import otp_pkg::*;
#(
    parameter int OCC_BITS = OCC_BITS_DEF
) (
    input  wire logic [OCC_BITS-1:0] i_acc [3],
    input  wire t_parse_flags        i_flags,
    input  wire t_cfg                i_cfg,
    output t_out_item                o_result
);

    localparam int CMP_W = (OCC_BITS > LIMIT_W) ? OCC_BITS : LIMIT_W;
    localparam int EXT_W = OCC_BITS + IDX_W;

    logic [OCC_BITS-1:0] occ [3];
    logic [1:0]          used;
    logic [1:0]          defined;
    logic [1:0]          minimal;
    logic                has_rec;
    logic                has_itm;
    logic                has_sub;
    logic                fail;
    logic                bad;
    logic                ok;
    logic                rec_ok;

    // accumulator to index field width
    function automatic logic [IDX_W-1:0] to_idx(input logic [OCC_BITS-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[IDX_W-1:0];
    endfunction

    // dimension counts
    always_comb begin
        has_rec = i_cfg.record_limit > LIMIT_W'(1);
        has_itm = i_cfg.item_limit > LIMIT_W'(1);
        has_sub = i_cfg.is_subitem & i_cfg.multiple_occurs;
        minimal = {1'b0, has_rec} + {1'b0, has_itm};
        used    = (i_flags.ptr > LAST_DIM) ? LAST_DIM : i_flags.ptr;
        defined = used + 2'd1;
        fail    = (defined != 2'd3) && (defined < minimal);
        bad     = fail || i_flags.error || (i_flags.paren_seen && !i_flags.close_seen);
    end

    // zero-based values, then shift missing dimensions into place
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < defined && i_acc[k] != '0) begin
                occ[k] = i_acc[k] - OCC_BITS'(1);
            end else begin
                occ[k] = '0;
            end
        end
        if (!fail && defined != 2'd3 && has_itm) begin
            if (defined == 2'd1) begin
                if (has_sub) begin
                    occ[2] = occ[0];
                end else begin
                    occ[1] = occ[0];
                end
                occ[0] = '0;
            end else if (defined == 2'd2 && has_sub) begin
                occ[2] = occ[1];
                occ[1] = '0;
            end
        end
    end

    // limit check
    always_comb begin
        rec_ok = CMP_W'(occ[0]) < CMP_W'(i_cfg.record_limit);
        if (i_cfg.is_subitem) begin
            ok = rec_ok && occ[1] == '0
                 && CMP_W'(occ[2]) < CMP_W'(i_cfg.item_limit);
        end else begin
            ok = rec_ok && CMP_W'(occ[1]) < CMP_W'(i_cfg.item_limit)
                 && occ[2] == '0;
        end
    end

    // result item
    always_comb begin
        if (bad) begin
            o_result = '0;
        end else begin
            o_result.parse_result  = (defined > 2'd2) ? 2'd2 : defined;
            o_result.record_index  = to_idx(occ[0]);
            o_result.itm_index     = to_idx(occ[1]);
            o_result.subitem_index = to_idx(occ[2]);
            o_result.accepted      = ok;
        end
    end

endmodule

`default_nettype wire

>>> rtl/occurrence_text_parser.sv
`default_nettype none

// Occurrence text parser. Characters of an occurrence string such as "(r,i,s)"
// arrive one per transfer on i_in, and a transfer with end_of_text set closes
// the string and yields exactly one result on o_out; character transfers yield
// none. It takes one item per cycle unless an end-of-text item waits on o_out:
// an input register feeds a single pass that updates the running parse state
// (the multiply-by-ten and saturate of the selected accumulator sets the path),
// and an end-of-text item goes from the input register to the result register,
// which holds while o_out is stalled; character items keep flowing meanwhile,
// and only an end-of-text item waits. The user must write limits and flags
// through the i_cfg_* port only while no text is in flight; it is not enforced.
module occurrence_text_parser
    import otp_pkg::*;
#(
    parameter int OCC_BITS = OCC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    otp_stream_if.sink                 i_in,
    otp_stream_if.source               o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ACC_EXT_W = OCC_BITS + 4;

    logic                r_in_valid;
    t_in_item            r_in;
    logic [OCC_BITS-1:0] r_acc [3];
    logic [OCC_BITS-1:0] n_acc [3];
    t_parse_flags        r_flags;
    t_parse_flags        n_flags;
    t_cfg                r_cfg;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                s2_adv;
    logic                s2_eot;
    logic [1:0]          sel;
    logic [3:0]          digit;
    logic [ACC_EXT_W-1:0] acc_ext;
    logic [ACC_EXT_W-1:0] mul;
    t_out_item           eval_result;

    // handshake
    assign s2_eot     = r_in_valid && r_in.end_of_text;
    assign s2_adv     = r_in_valid && (!r_in.end_of_text || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s2_adv;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // selected accumulator times ten plus digit
    always_comb begin
        sel     = (r_flags.ptr > LAST_DIM) ? LAST_DIM : r_flags.ptr;
        digit   = 4'(r_in.ch - CH_ZERO);
        acc_ext = ACC_EXT_W'(r_acc[sel]);
        mul     = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_W'(digit);
    end

    // character step and end-of-text clear
    always_comb begin
        n_acc   = r_acc;
        n_flags = r_flags;
        if (s2_adv) begin
            if (r_in.end_of_text) begin
                for (int k = 0; k < 3; k++) begin
                    n_acc[k] = '0;
                end
                n_flags = FLAGS_RESET;
            end else if (!r_flags.close_seen && !r_flags.error) begin
                case (r_in.ch)
                    CH_CLOSE: begin
                        n_flags.close_seen = 1'b1;
                    end
                    CH_SPACE: begin
                    end
                    CH_COMMA: begin
                        if (r_flags.ptr >= LAST_DIM) begin
                            n_flags.error = 1'b1;
                        end else begin
                            n_flags.ptr           = r_flags.ptr + 2'd1;
                            n_flags.paren_allowed = 1'b0;
                        end
                    end
                    CH_OPEN: begin
                        if (r_flags.paren_allowed) begin
                            n_flags.paren_seen    = 1'b1;
                            n_flags.paren_allowed = 1'b0;
                        end else begin
                            n_flags.error = 1'b1;
                        end
                    end
                    default: begin
                        if (r_in.ch inside {[CH_ZERO:CH_NINE]}) begin
                            // saturate at the accumulator width
                            if (|mul[ACC_EXT_W-1:OCC_BITS]) begin
                                n_acc[sel] = '1;
                            end else begin
                                n_acc[sel] = mul[OCC_BITS-1:0];
                            end
                            n_flags.paren_allowed = 1'b0;
                        end else begin
                            n_flags.error = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // end-of-text evaluation
    otp_eval #(
        .OCC_BITS (OCC_BITS)
    ) u_eval (
        .i_acc    (r_acc),
        .i_flags  (r_flags),
        .i_cfg    (r_cfg),
        .o_result (eval_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
            end
            r_flags <= FLAGS_RESET;
        end else begin
            r_acc   <= n_acc;
            r_flags <= n_flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv && s2_eot) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && s2_eot) begin
            r_out <= eval_result;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_RECORD_LIMIT:    r_cfg.record_limit    <= i_cfg_data;
                CFG_ITEM_LIMIT:      r_cfg.item_limit      <= i_cfg_data;
                CFG_IS_SUBITEM:      r_cfg.is_subitem      <= i_cfg_data[0];
                CFG_MULTIPLE_OCCURS: r_cfg.multiple_occurs <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // parse state returns to its idle value after end of text
    a_clear_after_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_adv && s2_eot) |=> (r_flags == FLAGS_RESET && r_acc[0] == '0))
        else $error("parse state not cleared after end of text");

    // end of text always produces a result
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_adv && s2_eot) |=> r_out_valid)
        else $error("end of text did not load a result");

    // pointer stays within the three dimensions
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.ptr != 2'd3)
        else $error("dimension pointer out of range");

    // an accepted index comes from a successful parse
    a_accept_needs_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |-> (r_out.parse_result != 2'd0))
        else $error("accepted without a successful parse");

endmodule

`default_nettype wire

>>> verif/occurrence_text_parser_test.sv
`timescale 1ns / 1ps

module occurrence_text_parser_test;
    import otp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_SETTINGS = 10;
    localparam int PHASE_CHARS  = 100;
    localparam longint unsigned ACC_MAX = (64'd1 << OCC_BITS_DEF) - 64'd1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    otp_stream_if #(.T(t_in_item))  in_chan ();
    otp_stream_if #(.T(t_out_item)) out_chan ();

    occurrence_text_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_chan),
        .o_out      (out_chan),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // register settings, one per phase: record limit, item limit, subitem, multiple
    int unsigned rec_set[NUM_SETTINGS]  = '{1, 5, 4, 3, 65535, 0, 1, 8, 65535, 2};
    int unsigned itm_set[NUM_SETTINGS]  = '{1, 3, 6, 5, 65535, 0, 7, 1, 1, 65535};
    bit          sub_set[NUM_SETTINGS]  = '{0, 0, 1, 1, 0, 1, 1, 0, 1, 0};
    bit          mult_set[NUM_SETTINGS] = '{0, 0, 1, 0, 1, 1, 1, 1, 1, 0};

    // idle percentages per phase: none, sender, receiver, both
    int unsigned send_idle_set[4] = '{0, 79, 0, 29};
    int unsigned recv_idle_set[4] = '{0, 0, 79, 29};

    // stimulus and expected results
    t_in_item  char_pending[$];
    t_out_item occ_expected[$];
    int        queued_cnt   = 0;
    int        accepted_cnt = 0;
    int        phase_chars  = 0;
    int        fail_cnt     = 0;
    int        cycle_cnt    = 0;
    int        sender_idle_pct = 0;
    int        recv_stall_pct  = 0;
    int        num_span        = 3;
    t_out_item exp_item;
    t_out_item got_item;

    // predictor copy of the registers
    logic [LIMIT_W-1:0] rec_lim  = 16'd1;
    logic [LIMIT_W-1:0] itm_lim  = 16'd1;
    logic               sub_flag = 1'b0;
    logic               mult_flag = 1'b0;

    // predictor copy of the parse state
    logic [OCC_BITS_DEF-1:0] acc_q[3] = '{default: '0};
    logic [1:0]              dim_ptr    = 2'd0;
    logic                    paren_ok   = 1'b1;
    logic                    paren_seen = 1'b0;
    logic                    close_seen = 1'b0;
    logic                    err_seen   = 1'b0;

    // result of a closed text from the current parse state
    function automatic t_out_item occ_result();
        longint unsigned occ[3];
        t_out_item       r;
        bit              has_rec;
        bit              has_itm;
        bit              has_sub;
        int              minimal;
        int              defined;
        bit              ok;

        occ = '{0, 0, 0};
        ok = 1'b0;
        r.parse_result = 2'd0;
        if (!err_seen && !(paren_seen && !close_seen)) begin
            has_rec = rec_lim > 1;
            has_itm = itm_lim > 1;
            has_sub = sub_flag && mult_flag;
            minimal = int'(has_rec) + int'(has_itm);
            defined = ((dim_ptr > LAST_DIM) ? int'(LAST_DIM) : int'(dim_ptr)) + 1;
            for (int k = 0; k < defined; k++) begin
                occ[k] = (acc_q[k] > 0) ? 64'(acc_q[k]) - 64'd1 : 64'd0;
            end
            // missing dimensions shift toward the item's own occurrence
            if (defined != 3 && defined < minimal) begin
                occ = '{0, 0, 0};
            end else begin
                if (defined != 3 && has_itm) begin
                    if (defined == 1) begin
                        occ[has_sub ? 2 : 1] = occ[0];
                        occ[0] = 0;
                    end else if (defined == 2 && has_sub) begin
                        occ[2] = occ[1];
                        occ[1] = 0;
                    end
                end
                r.parse_result = (defined > 2) ? 2'd2 : 2'(defined);
                ok = occ[0] < 64'(rec_lim);
                if (sub_flag)
                    ok = ok && occ[1] == 0 && occ[2] < 64'(itm_lim);
                else
                    ok = ok && occ[1] < 64'(itm_lim) && occ[2] == 0;
            end
        end
        r.record_index  = IDX_W'(occ[0]);
        r.itm_index     = IDX_W'(occ[1]);
        r.subitem_index = IDX_W'(occ[2]);
        r.accepted      = ok;
        return r;
    endfunction

    // advance the predicted parse by one accepted transfer
    task automatic parse_step(input t_in_item it);
        longint unsigned v;
        int              p;

        if (it.end_of_text) begin
            occ_expected.push_back(occ_result());
            acc_q      = '{default: '0};
            dim_ptr    = 2'd0;
            paren_ok   = 1'b1;
            paren_seen = 1'b0;
            close_seen = 1'b0;
            err_seen   = 1'b0;
        end else if (!close_seen && !err_seen && it.ch != CH_SPACE) begin
            if (it.ch == CH_CLOSE) begin
                close_seen = 1'b1;
            end else if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
                p = (dim_ptr > LAST_DIM) ? int'(LAST_DIM) : int'(dim_ptr);
                v = 64'(acc_q[p]) * 64'd10 + 64'(it.ch) - 64'(CH_ZERO);
                acc_q[p] = (v > ACC_MAX) ? OCC_BITS_DEF'(ACC_MAX) : OCC_BITS_DEF'(v);
                paren_ok = 1'b0;
            end else if (it.ch == CH_COMMA) begin
                // a third comma is an error
                if (dim_ptr >= LAST_DIM) begin
                    err_seen = 1'b1;
                end else begin
                    dim_ptr  = dim_ptr + 2'd1;
                    paren_ok = 1'b0;
                end
            end else if (it.ch == CH_OPEN && paren_ok) begin
                paren_seen = 1'b1;
                paren_ok   = 1'b0;
            end else begin
                err_seen = 1'b1;
            end
        end
    endtask

    // driver: next item once the current one is transferred
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_chan.valid <= 1'b0;
        end else if (!in_chan.valid || in_chan.ready) begin
            if (char_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_chan.valid   <= 1'b1;
                in_chan.payload <= char_pending.pop_front();
            end else begin
                in_chan.valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_chan.valid && in_chan.ready) begin
                parse_step(in_chan.payload);
                accepted_cnt++;
            end
            if (out_chan.valid && out_chan.ready) begin
                got_item = out_chan.payload;
                if (occ_expected.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: result=%0d rec=%0d item=%0d sub=%0d acc=%0d",
                                 got_item.parse_result, got_item.record_index,
                                 got_item.itm_index, got_item.subitem_index,
                                 got_item.accepted);
                end else begin
                    exp_item = occ_expected.pop_front();
                    if (got_item.parse_result !== exp_item.parse_result ||
                        got_item.record_index !== exp_item.record_index ||
                        got_item.itm_index !== exp_item.itm_index ||
                        got_item.subitem_index !== exp_item.subitem_index ||
                        got_item.accepted !== exp_item.accepted) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch: expected result=%0d rec=%0d item=%0d sub=%0d ",
                                      "acc=%0d, got result=%0d rec=%0d item=%0d sub=%0d acc=%0d"},
                                     exp_item.parse_result, exp_item.record_index,
                                     exp_item.itm_index, exp_item.subitem_index,
                                     exp_item.accepted, got_item.parse_result,
                                     got_item.record_index, got_item.itm_index,
                                     got_item.subitem_index, got_item.accepted);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic push_char(input logic [7:0] c);
        char_pending.push_back('{ch: c, end_of_text: 1'b0});
        queued_cnt++;
        phase_chars++;
    endtask

    // end marker with a random, ignored character
    task automatic push_eot();
        char_pending.push_back('{ch: 8'($urandom_range(255)), end_of_text: 1'b1});
        queued_cnt++;
        phase_chars++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    task automatic push_noise(input int max_len);
        int n;

        n = $urandom_range(1, max_len);
        repeat (n) push_char(8'($urandom_range(255)));
    endtask

    task automatic push_spaces();
        int n;

        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) push_char(CH_SPACE);
    endtask

    // one decimal field: mostly near the limits, sometimes empty, padded or huge
    task automatic push_num();
        int r;
        int n;

        r = $urandom_range(99);
        if (r < 8) begin
            n = 0;
        end else if (r < 75) begin
            push_str($sformatf("%0d", $urandom_range(1, num_span)));
        end else if (r < 85) begin
            push_char(CH_ZERO);
            push_str($sformatf("%0d", $urandom_range(0, num_span)));
        end else if (r < 95) begin
            push_str($sformatf("%0d", $urandom_range(0, 1100000)));
        end else begin
            // long enough to saturate
            n = $urandom_range(7, 10);
            repeat (n) push_char(CH_ZERO + 8'($urandom_range(9)));
            push_char(CH_NINE);
        end
    endtask

    // one random text: mostly well formed, the rest broken
    task automatic gen_text();
        int  ndim;
        int  roll;
        bit  paren;

        if ($urandom_range(99) < 75) begin
            paren = $urandom_range(2) != 0;
            if (paren) push_char(CH_OPEN);
            push_spaces();
            ndim = $urandom_range(1, 3);
            for (int d = 0; d < ndim; d++) begin
                if (d > 0) push_char(CH_COMMA);
                push_spaces();
                push_num();
                push_spaces();
            end
            if (paren ? $urandom_range(9) != 0 : $urandom_range(9) == 0)
                push_char(CH_CLOSE);
            if ($urandom_range(9) == 0) push_noise(3);
        end else begin
            roll = $urandom_range(3);
            case (roll)
                0: begin
                    push_noise(6);
                end
                1: begin
                    // four dimensions
                    repeat (3) begin
                        push_num();
                        push_char(CH_COMMA);
                    end
                    push_num();
                end
                2: begin
                    // misplaced open parenthesis
                    if ($urandom_range(1)) push_char(CH_OPEN);
                    else push_num();
                    push_char(CH_OPEN);
                    push_num();
                    push_char(CH_CLOSE);
                end
                default: begin
                    push_num();
                    push_char(8'($urandom_range(255)));
                    push_num();
                end
            endcase
        end
        push_eot();
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_RECORD_LIMIT: rec_lim   = data;
            CFG_ITEM_LIMIT:   itm_lim   = data;
            CFG_IS_SUBITEM:   sub_flag  = data[0];
            default:          mult_flag = data[0];
        endcase
    endtask

    // wait until all transfers and results are done, then let the pipe drain
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || occ_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_texts();
        push_eot();
        push_str("(9,8,7)");
        push_eot();
        push_str("((1)");
        push_eot();
        push_str("1,2,3,4");
        push_eot();
        push_str("99999999");
        push_eot();
        push_str("(1");
        push_eot();
        push_str(" 1)x");
        push_eot();
        push_str("1(");
        push_eot();
        push_str(" 0 ,2");
        push_eot();
        push_char(8'hff);
        push_char(8'h00);
        push_eot();
    endtask

    // main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_RECORD_LIMIT;
        i_cfg_data      = '0;
        in_chan.valid   = 1'b0;
        in_chan.payload = '0;
        out_chan.ready  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            wait_idle();
            write_reg(CFG_RECORD_LIMIT, CFG_DATA_W'(rec_set[ph]));
            write_reg(CFG_ITEM_LIMIT, CFG_DATA_W'(itm_set[ph]));
            write_reg(CFG_IS_SUBITEM, CFG_DATA_W'(sub_set[ph]));
            write_reg(CFG_MULTIPLE_OCCURS, CFG_DATA_W'(mult_set[ph]));
            @(posedge i_clk);
            i_cfg_we <= 1'b0;

            sender_idle_pct = send_idle_set[ph % 4];
            recv_stall_pct  = recv_idle_set[ph % 4];
            num_span = ((rec_set[ph] > itm_set[ph]) ? rec_set[ph] : itm_set[ph]);
            num_span = ((num_span > 40) ? 40 : num_span) + 2;

            if (ph == 0) directed_texts();
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) gen_text();
        end
        wait_idle();

        if (fail_cnt == 0 && occ_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> occurrence_text_parser.f
rtl/otp_pkg.sv
rtl/otp_stream_if.sv
rtl/otp_eval.sv
rtl/occurrence_text_parser.sv
verif/occurrence_text_parser_test.sv
